### rtl/core/conv_weight_gradient_top_assert.svh
// Assertion macros for the top level, which checks its own logic.
`ifndef CONV_WEIGHT_GRADIENT_TOP_ASSERT_SVH
`define CONV_WEIGHT_GRADIENT_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CWG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CWG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/core/cwg_pkg.sv
`timescale 1ns / 1ps

package cwg_pkg;

  localparam int GRAD_WORDS = 4096;
  localparam int ACT_WORDS  = 4096;
  localparam int MAX_DIM    = 16;
  localparam int DATA_BITS  = 16;

  localparam int GRAD_AW   = $clog2(GRAD_WORDS);
  localparam int ACT_AW    = $clog2(ACT_WORDS);
  localparam int DIM_W     = 5;
  localparam int IDX_W     = 4;
  localparam int SUM_W     = 40;
  localparam int CFG_IDX_W = 3;
  localparam int ADDR_W    = 12;

  // Shared multiply-add unit: r = a * b + c.
  localparam int MA_A_W = 20;
  localparam int MA_B_W = DIM_W;
  localparam int MA_C_W = DIM_W;
  localparam int MA_R_W = MA_A_W + MA_B_W;

  localparam int WIN_W = 2 * DIM_W - 1;

  localparam logic [1:0] MODE_LOAD_GRAD = 2'd0;
  localparam logic [1:0] MODE_LOAD_ACT  = 2'd1;
  localparam logic [1:0] MODE_CALC      = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_GRAD_CHANS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRAD_GROUPS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILT_H      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILT_W      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IN_CHANS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_H       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_W       = 3'd6;

  typedef struct packed {
    logic [DIM_W-1:0] grad_chans;
    logic [DIM_W-1:0] grad_groups;
    logic [DIM_W-1:0] filt_h;
    logic [DIM_W-1:0] filt_w;
    logic [DIM_W-1:0] in_chans;
    logic [DIM_W-1:0] map_h;
    logic [DIM_W-1:0] map_w;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] example;
    logic [IDX_W-1:0] chan;
    logic [IDX_W-1:0] group;
    logic [IDX_W-1:0] wrow;
    logic [IDX_W-1:0] wcol;
    logic [IDX_W-1:0] in_chan;
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic [MA_A_W-1:0] a;
    logic [MA_B_W-1:0] b;
    logic [MA_C_W-1:0] c;
  } ma_op_t;

  typedef struct packed {
    logic               rd_en;
    logic [GRAD_AW-1:0] gaddr;
    logic [ACT_AW-1:0]  aaddr;
    logic               mac_clr;
    logic               mac_issue;
    logic               res_load;
    logic               res_err;
  } ctrl_t;

  typedef struct packed {
    logic busy;
  } mac_st_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK,
    S_G1,
    S_G2,
    S_G3,
    S_G4,
    S_A1,
    S_A2,
    S_A3,
    S_WIN,
    S_AEND,
    S_ASTART,
    S_TEST,
    S_RUN,
    S_DRAIN,
    S_DONE
  } seq_state_t;

  function automatic logic reg_ok(input logic [DIM_W-1:0] r);
    reg_ok = (r != '0) && (r <= DIM_W'(MAX_DIM));
  endfunction

endpackage

### rtl/core/cwg_ram.sv
`timescale 1ns / 1ps

module cwg_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/cwg_muladd.sv
`timescale 1ns / 1ps

module cwg_muladd
  import cwg_pkg::*;
(
  input  logic              clk,
  input  ma_op_t            op,
  output logic [MA_R_W-1:0] res
);

  logic [MA_R_W-1:0] res_r;
  logic [MA_R_W-1:0] res_nxt;

  assign res_nxt = MA_R_W'(op.a) * MA_R_W'(op.b) + MA_R_W'(op.c);

  always_ff @(posedge clk) begin
    if (op.en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

### rtl/core/cwg_mac.sv
`timescale 1ns / 1ps

module cwg_mac
  import cwg_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clr,
  input  logic                        issue,
  input  logic signed [DATA_BITS-1:0] gdata,
  input  logic signed [DATA_BITS-1:0] adata,
  output logic signed [SUM_W-1:0]     acc,
  output mac_st_t                     st
);

  logic                          issue_d_r;
  logic                          prod_vld_r;
  logic signed [2*DATA_BITS-1:0] prod_r;
  logic signed [SUM_W-1:0]       acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_d_r  <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      issue_d_r  <= issue;
      prod_vld_r <= issue_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (issue_d_r) begin
      prod_r <= gdata * adata;
    end
    if (clr) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + SUM_W'(prod_r);
    end
  end

  assign acc     = acc_r;
  assign st.busy = issue_d_r | prod_vld_r;

endmodule

### rtl/core/cwg_seq.sv
`timescale 1ns / 1ps

module cwg_seq
  import cwg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              start,
  input  cmd_t              cmd,
  input  logic [MA_R_W-1:0] ma_res,
  input  mac_st_t           mac_st,
  input  logic              out_free,
  output ma_op_t            ma_op,
  output ctrl_t             ctrl,
  output logic              idle
);

  seq_state_t         state_r;
  seq_state_t         state_nxt;
  cmd_t               cmd_r;
  logic               err_r;
  logic               aerr_r;
  logic [MA_A_W-1:0]  gbase_r;
  logic [MA_A_W-1:0]  abase_r;
  logic [WIN_W-1:0]   win_r;
  logic [GRAD_AW-1:0] gaddr_r;
  logic [ACT_AW-1:0]  aaddr_r;
  logic [DIM_W-1:0]   m2_r;
  logic [WIN_W-1:0]   cnt_r;

  logic [DIM_W:0]   ah_sum;
  logic [DIM_W:0]   aw_sum;
  logic [DIM_W:0]   hend_sum;
  logic [DIM_W:0]   wend_sum;
  logic [DIM_W-1:0] ah;
  logic [DIM_W-1:0] aw;
  logic             bad_cfg;
  logic             bad_idx;
  logic             gerr;
  logic             test_err;
  logic             row_end;
  logic             last_issue;

  assign ah_sum   = {1'b0, cfg.filt_h} + {1'b0, cfg.map_h} - (DIM_W + 1)'(1);
  assign aw_sum   = {1'b0, cfg.filt_w} + {1'b0, cfg.map_w} - (DIM_W + 1)'(1);
  assign hend_sum = (DIM_W + 1)'(cmd_r.wrow) + {1'b0, cfg.map_h} - (DIM_W + 1)'(1);
  assign wend_sum = (DIM_W + 1)'(cmd_r.wcol) + {1'b0, cfg.map_w} - (DIM_W + 1)'(1);
  assign ah       = ah_sum[DIM_W-1:0];
  assign aw       = aw_sum[DIM_W-1:0];

  assign bad_cfg = !reg_ok(cfg.grad_chans) || !reg_ok(cfg.grad_groups) ||
                   !reg_ok(cfg.filt_h) || !reg_ok(cfg.filt_w) ||
                   !reg_ok(cfg.in_chans) || !reg_ok(cfg.map_h) || !reg_ok(cfg.map_w);
  assign bad_idx = (DIM_W'(cmd_r.chan) >= cfg.grad_chans) ||
                   (DIM_W'(cmd_r.group) >= cfg.grad_groups) ||
                   (DIM_W'(cmd_r.wrow) >= cfg.filt_h) ||
                   (DIM_W'(cmd_r.wcol) >= cfg.filt_w) ||
                   (DIM_W'(cmd_r.in_chan) >= cfg.in_chans);

  assign gerr       = ({1'b0, gbase_r} + (MA_A_W + 1)'(win_r)) > (MA_A_W + 1)'(GRAD_WORDS);
  assign test_err   = gerr || aerr_r;
  assign row_end    = (m2_r == cfg.map_w - DIM_W'(1));
  assign last_issue = (cnt_r == win_r - WIN_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_r <= cmd;
          err_r <= 1'b0;
        end
      end
      S_CHK: begin
        err_r <= bad_cfg || bad_idx;
      end
      S_A1: begin
        gbase_r <= ma_res[MA_A_W-1:0];
      end
      S_WIN: begin
        abase_r <= ma_res[MA_A_W-1:0];
      end
      S_AEND: begin
        win_r <= ma_res[WIN_W-1:0];
      end
      S_ASTART: begin
        aerr_r <= ({1'b0, abase_r} + (MA_A_W + 1)'(ma_res[MA_A_W-1:0])) >=
                  (MA_A_W + 1)'(ACT_WORDS);
      end
      S_TEST: begin
        err_r   <= test_err;
        gaddr_r <= gbase_r[GRAD_AW-1:0];
        aaddr_r <= abase_r[ACT_AW-1:0] + ma_res[ACT_AW-1:0];
        m2_r    <= '0;
        cnt_r   <= '0;
      end
      S_RUN: begin
        gaddr_r <= gaddr_r + GRAD_AW'(1);
        cnt_r   <= cnt_r + WIN_W'(1);
        if (row_end) begin
          m2_r    <= '0;
          aaddr_r <= aaddr_r + ACT_AW'(cfg.filt_w);
        end else begin
          m2_r    <= m2_r + DIM_W'(1);
          aaddr_r <= aaddr_r + ACT_AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (start) state_nxt = S_CHK;
      S_CHK:    state_nxt = (bad_cfg || bad_idx) ? S_DONE : S_G1;
      S_G1:     state_nxt = S_G2;
      S_G2:     state_nxt = S_G3;
      S_G3:     state_nxt = S_G4;
      S_G4:     state_nxt = S_A1;
      S_A1:     state_nxt = S_A2;
      S_A2:     state_nxt = S_A3;
      S_A3:     state_nxt = S_WIN;
      S_WIN:    state_nxt = S_AEND;
      S_AEND:   state_nxt = S_ASTART;
      S_ASTART: state_nxt = S_TEST;
      S_TEST:   state_nxt = test_err ? S_DONE : S_RUN;
      S_RUN:    if (last_issue) state_nxt = S_DRAIN;
      S_DRAIN:  if (!mac_st.busy) state_nxt = S_DONE;
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ma_op          = '0;
    ctrl           = '0;
    ctrl.gaddr     = gaddr_r;
    ctrl.aaddr     = aaddr_r;
    ctrl.res_err   = err_r;
    idle           = 1'b0;
    case (state_r)
      S_IDLE: begin
        idle = 1'b1;
      end
      S_G1: begin
        ma_op = '{en: 1'b1, a: MA_A_W'(cmd_r.example), b: cfg.grad_chans,
                  c: MA_C_W'(cmd_r.chan)};
      end
      S_G2: begin
        ma_op = '{en: 1'b1, a: ma_res[MA_A_W-1:0], b: cfg.grad_groups,
                  c: MA_C_W'(cmd_r.group)};
      end
      S_G3: begin
        ma_op = '{en: 1'b1, a: ma_res[MA_A_W-1:0], b: cfg.map_h, c: '0};
      end
      S_G4: begin
        ma_op = '{en: 1'b1, a: ma_res[MA_A_W-1:0], b: cfg.map_w, c: '0};
      end
      S_A1: begin
        ma_op = '{en: 1'b1, a: MA_A_W'(cmd_r.example), b: cfg.in_chans,
                  c: MA_C_W'(cmd_r.in_chan)};
      end
      S_A2: begin
        ma_op = '{en: 1'b1, a: ma_res[MA_A_W-1:0], b: ah, c: '0};
      end
      S_A3: begin
        ma_op = '{en: 1'b1, a: ma_res[MA_A_W-1:0], b: aw, c: '0};
      end
      S_WIN: begin
        ma_op = '{en: 1'b1, a: MA_A_W'(cfg.map_h), b: cfg.map_w, c: '0};
      end
      S_AEND: begin
        ma_op = '{en: 1'b1, a: MA_A_W'(hend_sum[DIM_W-1:0]), b: aw,
                  c: wend_sum[DIM_W-1:0]};
      end
      S_ASTART: begin
        ma_op = '{en: 1'b1, a: MA_A_W'(cmd_r.wrow), b: aw, c: MA_C_W'(cmd_r.wcol)};
      end
      S_TEST: begin
        ctrl.mac_clr = 1'b1;
      end
      S_RUN: begin
        ctrl.rd_en     = 1'b1;
        ctrl.mac_issue = 1'b1;
      end
      S_DONE: begin
        ctrl.res_load = out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/conv_weight_gradient_top.sv
`timescale 1ns / 1ps
// Channel  Direction  Group                        Contents
// in       slave      in_tvalid/in_tready/tdata    load word or weight request
// out      master     out_tvalid/out_tready/tdata  weight gradient sum and error
// cfg      slave      cfg_valid/cfg_ready          register index and write data
//
// A load transaction is taken while the core is idle and yields no result.
// A compute transaction first sets up addresses on the shared multiply-add unit, then
// streams map_h * map_w word pairs through the single multiply-accumulate, drains it and
// hands the result over; it ends early when a register or index check fails or when the
// window reaches beyond a store.
// The input is not ready while a compute is in progress; a finished result waits in the
// output register, and only the next compute result stalls behind it.
// Reset is synchronous, active low; the stores are not cleared.

module conv_weight_gradient_top
  import cwg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // addr[11:0], value[27:12], example[31:28], chan[35:32], group[39:36],
  // wrow[43:40], wcol[47:44], in_chan[51:48], zero pad[55:52]
  input  logic [55:0]          in_tdata,
  // mode[1:0]
  input  logic [1:0]           in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // sum[39:0]
  output logic [SUM_W-1:0]     out_tdata,
  // error[0]
  output logic                 out_tuser,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  logic [ADDR_W-1:0]           in_addr;
  logic signed [DATA_BITS-1:0] in_value;
  cmd_t                        in_cmd;
  logic                        in_acc;
  logic                        start;
  logic                        gwe;
  logic                        awe;

  cfg_t                        cfg_r;
  ma_op_t                      ma_op;
  logic [MA_R_W-1:0]           ma_res;
  ctrl_t                       seq_ctrl;
  mac_st_t                     mac_st;
  logic                        seq_idle;
  logic signed [DATA_BITS-1:0] gdata;
  logic signed [DATA_BITS-1:0] adata;
  logic signed [SUM_W-1:0]     acc;
  logic                        out_free;

  logic                        out_tvalid_r;
  logic [SUM_W-1:0]            out_sum_r;
  logic                        out_err_r;

  assign in_addr        = in_tdata[11:0];
  assign in_value       = in_tdata[27:12];
  assign in_cmd.example = in_tdata[31:28];
  assign in_cmd.chan    = in_tdata[35:32];
  assign in_cmd.group   = in_tdata[39:36];
  assign in_cmd.wrow    = in_tdata[43:40];
  assign in_cmd.wcol    = in_tdata[47:44];
  assign in_cmd.in_chan = in_tdata[51:48];

  assign in_tready = seq_idle;
  assign in_acc    = in_tvalid && in_tready;
  assign start     = in_acc && (in_tuser == MODE_CALC);
  assign gwe       = in_acc && (in_tuser == MODE_LOAD_GRAD) &&
                     ({20'd0, in_addr} < 32'(GRAD_WORDS));
  assign awe       = in_acc && (in_tuser == MODE_LOAD_ACT) &&
                     ({20'd0, in_addr} < 32'(ACT_WORDS));

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{default: DIM_W'(1)};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GRAD_CHANS:  cfg_r.grad_chans  <= cfg_data;
        REG_GRAD_GROUPS: cfg_r.grad_groups <= cfg_data;
        REG_FILT_H:      cfg_r.filt_h      <= cfg_data;
        REG_FILT_W:      cfg_r.filt_w      <= cfg_data;
        REG_IN_CHANS:    cfg_r.in_chans    <= cfg_data;
        REG_MAP_H:       cfg_r.map_h       <= cfg_data;
        REG_MAP_W:       cfg_r.map_w       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  cwg_ram #(
    .DEPTH(GRAD_WORDS),
    .WIDTH(DATA_BITS)
  ) u_grad_ram (
    .clk  (clk),
    .we   (gwe),
    .waddr(GRAD_AW'(in_addr)),
    .wdata(DATA_BITS'(in_value)),
    .re   (seq_ctrl.rd_en),
    .raddr(seq_ctrl.gaddr),
    .rdata(gdata)
  );

  cwg_ram #(
    .DEPTH(ACT_WORDS),
    .WIDTH(DATA_BITS)
  ) u_act_ram (
    .clk  (clk),
    .we   (awe),
    .waddr(ACT_AW'(in_addr)),
    .wdata(DATA_BITS'(in_value)),
    .re   (seq_ctrl.rd_en),
    .raddr(seq_ctrl.aaddr),
    .rdata(adata)
  );

  cwg_muladd u_muladd (
    .clk(clk),
    .op (ma_op),
    .res(ma_res)
  );

  cwg_mac u_mac (
    .clk  (clk),
    .rst_n(rst_n),
    .clr  (seq_ctrl.mac_clr),
    .issue(seq_ctrl.mac_issue),
    .gdata(gdata),
    .adata(adata),
    .acc  (acc),
    .st   (mac_st)
  );

  cwg_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .start   (start),
    .cmd     (in_cmd),
    .ma_res  (ma_res),
    .mac_st  (mac_st),
    .out_free(out_free),
    .ma_op   (ma_op),
    .ctrl    (seq_ctrl),
    .idle    (seq_idle)
  );

  assign out_free = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (seq_ctrl.res_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_ctrl.res_load) begin
      out_sum_r <= seq_ctrl.res_err ? '0 : acc;
      out_err_r <= seq_ctrl.res_err;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_sum_r;
  assign out_tuser  = out_err_r;

`include "conv_weight_gradient_top_assert.svh"

  `CWG_ASSERT_NEXT(a_calc_holds_input, clk, rst_n, start, !in_tready)
  `CWG_ASSERT_IMPL(a_error_sum_zero, clk, rst_n, out_tvalid && out_tuser, out_tdata == '0)
  `CWG_ASSERT_IMPL(a_no_overwrite, clk, rst_n, seq_ctrl.res_load, !out_tvalid || out_tready)
  `CWG_ASSERT_IMPL(a_idle_mac_quiet, clk, rst_n, in_tready, !mac_st.busy)

endmodule
